// File: src/vscc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fp32 helpers for the visible splat cull/compact block.
// No dependencies.
package vscc_pkg;

    localparam int PAGE_SLOTS = 16;
    localparam int INDEX_BITS = 24;
    localparam int SLOT_BITS  = $clog2(PAGE_SLOTS);
    localparam int CNT_BITS   = 25;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);

    localparam logic [INDEX_BITS-1:0] IDX_TOP = {INDEX_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]   CNT_TOP = {1'b1, {(CNT_BITS-1){1'b0}}};

    localparam logic [1:0] KIND_REC = 2'd0;
    localparam logic [1:0] KIND_PAD = 2'd1;
    localparam logic [1:0] KIND_CNT = 2'd2;

    localparam logic [2:0] CFG_COUNT_MODE   = 3'd0;
    localparam logic [2:0] CFG_BASE_INDEX   = 3'd1;
    localparam logic [2:0] CFG_PAD_TAIL     = 3'd2;
    localparam logic [2:0] CFG_OPAC_FLOOR   = 3'd3;
    localparam logic [2:0] CFG_NEAR_DEPTH   = 3'd4;
    localparam logic [2:0] CFG_VIEW_W       = 3'd5;
    localparam logic [2:0] CFG_VIEW_H       = 3'd6;
    localparam logic [2:0] CFG_RAD_LIMIT    = 3'd7;

    localparam logic [31:0] FP_NAN = 32'h7fc0_0000;

    typedef struct packed {
        logic [63:0] mean_xy;
        logic [63:0] radius_xy;
        logic [63:0] conic_ab;
        logic [63:0] conic_c_depth;
        logic [63:0] color_rg;
        logic [63:0] color_b_opacity;
        logic        end_of_stream;
    } in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [INDEX_BITS-1:0] out_index;
        logic [63:0]           out_mean_xy;
        logic [63:0]           out_radius_xy;
        logic [63:0]           out_conic_ab;
        logic [63:0]           out_conic_c_depth;
        logic [63:0]           out_color_rg;
        logic [63:0]           out_color_b_opacity;
        logic [CNT_BITS-1:0]   visible_total;
        logic                  last_of_run;
    } out_t;

    typedef struct packed {
        logic                  count_mode;
        logic [INDEX_BITS-1:0] base_index;
        logic                  pad_tail;
        logic [31:0]           opac_floor;
        logic [31:0]           near_depth;
        logic [31:0]           view_w;
        logic [31:0]           view_h;
        logic [31:0]           rad_limit;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        in_t  item;
        logic vis;
        logic cm;
        logic pt;
    } entry_t;

    function automatic logic fp_nan(input logic [31:0] a);
        fp_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
        if (fp_nan(a) || fp_nan(b))
            fp_lt = 1'b0;
        else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            fp_lt = 1'b0;
        else if (a[31] != b[31])
            fp_lt = a[31];
        else if (!a[31])
            fp_lt = a[30:0] < b[30:0];
        else
            fp_lt = a[30:0] > b[30:0];
    endfunction

    function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
        fp_le = fp_lt(a, b) || (!fp_nan(a) && !fp_nan(b) &&
                ((a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))));
    endfunction

    // round-to-nearest-even fp32 add, denormals kept
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [26:0] ax;
        logic [26:0] ay;
        logic [7:0]  d;
        logic        sticky;
        logic [27:0] s;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [9:0]  sh;
        logic [24:0] m;
        logic        up;
        logic        lo;
        logic [31:0] res;
        if ((a[30:23] == 8'hff) || (b[30:23] == 8'hff)) begin
            if (fp_nan(a) || fp_nan(b) ||
                ((a[30:0] == b[30:0]) && (a[31] != b[31])))
                res = FP_NAN;
            else
                res = (a[30:23] == 8'hff) ? a : b;
        end
        else begin
            if (a[30:0] < b[30:0]) begin
                x = b;
                y = a;
            end
            else begin
                x = a;
                y = b;
            end
            ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
            ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
            ax = {(x[30:23] != 8'd0), x[22:0], 3'b000};
            ay = {(y[30:23] != 8'd0), y[22:0], 3'b000};
            d  = ex - ey;
            if (d >= 8'd27) begin
                sticky = |ay;
                ay = 27'd0;
            end
            else begin
                sticky = |(ay & ((27'd1 << d) - 27'd1));
                ay = ay >> d;
            end
            ay[0] = ay[0] | sticky;
            if (x[31] == y[31])
                s = {1'b0, ax} + {1'b0, ay};
            else
                s = {1'b0, ax} - {1'b0, ay};
            e = {2'b00, ex};
            if (s == 28'd0)
                res = 32'd0;
            else begin
                if (s[27]) begin
                    lo = s[0];
                    s = s >> 1;
                    s[0] = s[0] | lo;
                    e = e + 10'd1;
                end
                else begin
                    lz = 5'd0;
                    for (int i = 0; i < 27; i++) begin
                        if (s[i])
                            lz = 5'(26 - i);
                    end
                    sh = ({5'd0, lz} < (e - 10'd1)) ? {5'd0, lz} : (e - 10'd1);
                    s = s << sh;
                    e = e - sh;
                end
                up = s[2] && (s[1] || s[0] || s[3]);
                m = {1'b0, s[26:3]} + {24'd0, up};
                if (m[24]) begin
                    m = m >> 1;
                    e = e + 10'd1;
                end
                if (e >= 10'd255)
                    res = {x[31], 8'hff, 23'd0};
                else
                    res = {x[31], (m[23] ? e[7:0] : 8'd0), m[22:0]};
            end
        end
        fp_add = res;
    endfunction

endpackage

// File: src/vscc_front.sv
`timescale 1ns / 1ps
// Front end: registers items, forms footprint bounds, classifies visibility.
// Depends on vscc_pkg.
module vscc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  vscc_pkg::in_t   in_data,
    input  vscc_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            q_push,
    output vscc_pkg::entry_t q_entry
);
    import vscc_pkg::*;

    logic        s1_valid_reg;
    in_t         s1_data_reg;
    logic        s2_valid_reg;
    in_t         s2_data_reg;
    logic [31:0] xhi_reg;
    logic [31:0] xlo_reg;
    logic [31:0] yhi_reg;
    logic [31:0] ylo_reg;
    logic        en;
    logic        drop;
    logic        vis;
    logic [31:0] rx;
    logic [31:0] ry;

    assign en       = !s2_valid_reg || !q_full;
    assign in_stall = !en;
    assign q_push   = s2_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_data_reg <= in_data;
            s2_data_reg <= s1_data_reg;
            xhi_reg <= fp_add(s1_data_reg.mean_xy[31:0], s1_data_reg.radius_xy[31:0]);
            xlo_reg <= fp_add(s1_data_reg.mean_xy[31:0],
                              {~s1_data_reg.radius_xy[31], s1_data_reg.radius_xy[30:0]});
            yhi_reg <= fp_add(s1_data_reg.mean_xy[63:32], s1_data_reg.radius_xy[63:32]);
            ylo_reg <= fp_add(s1_data_reg.mean_xy[63:32],
                              {~s1_data_reg.radius_xy[63], s1_data_reg.radius_xy[62:32]});
        end
    end

    always_comb
    begin
        rx   = s2_data_reg.radius_xy[31:0];
        ry   = s2_data_reg.radius_xy[63:32];
        drop = fp_le(s2_data_reg.conic_c_depth[63:32], cfg.near_depth) ||
               fp_lt(s2_data_reg.color_b_opacity[63:32], cfg.opac_floor);
        vis  = !drop &&
               fp_lt(32'd0, xhi_reg) && fp_lt(xlo_reg, cfg.view_w) &&
               fp_lt(32'd0, yhi_reg) && fp_lt(ylo_reg, cfg.view_h) &&
               fp_lt(32'd0, rx) && fp_lt(32'd0, ry) &&
               fp_le(rx, cfg.rad_limit) && fp_le(ry, cfg.rad_limit);
        q_entry.item = s2_data_reg;
        q_entry.vis  = vis;
        q_entry.cm   = cfg.count_mode;
        q_entry.pt   = cfg.pad_tail;
    end

endmodule

// File: src/vscc_queue.sv
`timescale 1ns / 1ps
// Small FIFO between the classifier and the emitter.
// Depends on vscc_pkg.
module vscc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vscc_pkg::entry_t  wdata,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output vscc_pkg::entry_t  rdata
);
    import vscc_pkg::*;

    entry_t                mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_reg;
    logic [QPTR_BITS-1:0]  rd_reg;
    logic [QPTR_BITS:0]    cnt_reg;
    logic [QPTR_BITS:0]    cnt_next;

    assign full      = cnt_reg == (QPTR_BITS+1)'(QDEPTH);
    assign not_empty = cnt_reg != '0;
    assign rdata     = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

endmodule

// File: src/vscc_back.sv
`timescale 1ns / 1ps
// Back end: compact indexing, visible count, tail padding, output register.
// Depends on vscc_pkg.
module vscc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  vscc_pkg::entry_t q_head,
    output logic             q_pop,
    input  logic [vscc_pkg::INDEX_BITS-1:0] base_index,
    output logic             out_valid,
    input  logic             out_stall,
    output vscc_pkg::out_t   out_data
);
    import vscc_pkg::*;

    logic [INDEX_BITS-1:0] nidx_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  open_reg;
    logic                  pad_reg;
    logic [SLOT_BITS:0]    rem_reg;
    logic [INDEX_BITS-1:0] pidx_reg;
    logic                  ov_reg;
    out_t                  out_reg;

    logic                  free;
    logic [INDEX_BITS-1:0] eff_idx;
    logic [CNT_BITS-1:0]   eff_cnt;
    logic [INDEX_BITS-1:0] idx_after;
    logic [CNT_BITS-1:0]   cnt_after;
    logic [SLOT_BITS-1:0]  slot;
    logic                  rec;
    logic                  rpt;
    logic                  need_pad;
    logic                  take;
    logic                  emit;
    out_t                  res;

    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign free      = !ov_reg || !out_stall;

    always_comb
    begin
        eff_idx   = open_reg ? nidx_reg : base_index;
        eff_cnt   = open_reg ? cnt_reg : '0;
        rec       = q_head.vis && !q_head.cm;
        rpt       = q_head.item.end_of_stream && q_head.cm;
        idx_after = (rec && eff_idx != IDX_TOP) ? eff_idx + 1'b1 : eff_idx;
        cnt_after = (q_head.vis && eff_cnt < CNT_TOP) ? eff_cnt + 1'b1 : eff_cnt;
        slot      = idx_after[SLOT_BITS-1:0];
        need_pad  = q_head.item.end_of_stream && !q_head.cm && q_head.pt && slot != '0;
        take      = free && q_valid;
        q_pop     = take && (pad_reg ? rem_reg == (SLOT_BITS+1)'(1) : !need_pad);

        res = '0;
        if (pad_reg)
        begin
            emit            = 1'b1;
            res.kind        = KIND_PAD;
            res.out_index   = pidx_reg;
            res.last_of_run = rem_reg == (SLOT_BITS+1)'(1);
        end
        else
        begin
            emit            = rec || rpt;
            res.last_of_run = !need_pad;
            if (rpt)
            begin
                res.kind          = KIND_CNT;
                res.visible_total = cnt_after;
            end
            else
            begin
                res.kind                = KIND_REC;
                res.out_index           = eff_idx;
                res.out_mean_xy         = q_head.item.mean_xy;
                res.out_radius_xy       = q_head.item.radius_xy;
                res.out_conic_ab        = q_head.item.conic_ab;
                res.out_conic_c_depth   = q_head.item.conic_c_depth;
                res.out_color_rg        = q_head.item.color_rg;
                res.out_color_b_opacity = q_head.item.color_b_opacity;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nidx_reg <= '0;
            cnt_reg  <= '0;
            open_reg <= 1'b0;
            pad_reg  <= 1'b0;
            rem_reg  <= '0;
            pidx_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (free)
                ov_reg <= take && emit;
            if (take)
            begin
                if (pad_reg)
                begin
                    rem_reg <= rem_reg - 1'b1;
                    if (pidx_reg != IDX_TOP)
                        pidx_reg <= pidx_reg + 1'b1;
                    if (rem_reg == (SLOT_BITS+1)'(1))
                        pad_reg <= 1'b0;
                end
                else
                begin
                    nidx_reg <= idx_after;
                    cnt_reg  <= cnt_after;
                    open_reg <= !q_head.item.end_of_stream;
                    if (need_pad)
                    begin
                        pad_reg  <= 1'b1;
                        pidx_reg <= idx_after;
                        rem_reg  <= (SLOT_BITS+1)'(PAGE_SLOTS) - {1'b0, slot};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            out_reg <= res;
    end

endmodule

// File: src/visible_splat_cull_compact_unit.sv
`timescale 1ns / 1ps
// Visible splat cull and compaction, top level. Depends on vscc_pkg and submodules.
// Throughput: one item per cycle while out_stall is low; an end-of-stream item with
// padding holds the emitter until its pads are sent (up to PAGE_SLOTS-1 pads).
// The fp32 bounds adders in the front stage set the pipeline depth.
// Reset (rst_n low, async): config and control registers zero, stream closed, queue and output empty.
module visible_splat_cull_compact_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  vscc_pkg::in_t         in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output vscc_pkg::out_t        out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import vscc_pkg::*;

    cfg_t   cfg_reg;
    logic   q_full;
    logic   q_push;
    entry_t q_wdata;
    logic   q_pop;
    logic   q_valid;
    entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUNT_MODE: cfg_reg.count_mode <= cfg_data[0];
                CFG_BASE_INDEX: cfg_reg.base_index <= cfg_data[INDEX_BITS-1:0];
                CFG_PAD_TAIL:   cfg_reg.pad_tail   <= cfg_data[0];
                CFG_OPAC_FLOOR: cfg_reg.opac_floor <= cfg_data;
                CFG_NEAR_DEPTH: cfg_reg.near_depth <= cfg_data;
                CFG_VIEW_W:     cfg_reg.view_w     <= cfg_data;
                CFG_VIEW_H:     cfg_reg.view_h     <= cfg_data;
                CFG_RAD_LIMIT:  cfg_reg.rad_limit  <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    vscc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_wdata)
    );

    vscc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rdata     (q_head)
    );

    vscc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .base_index (cfg_reg.base_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// File: src/vscc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the cull/compact top level, bound in below.
// Depends on vscc_pkg.
module vscc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input vscc_pkg::out_t out_data
);
    import vscc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kind == KIND_REC || out_data.kind == KIND_PAD ||
                      out_data.kind == KIND_CNT)
        else $error("bad result kind");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_PAD |->
            out_data.out_mean_xy == '0 && out_data.out_color_b_opacity == '0 &&
            out_data.visible_total == '0)
        else $error("pad record not zero");

    a_cnt_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_CNT |->
            out_data.last_of_run && out_data.out_index == '0)
        else $error("count report malformed");

endmodule

bind visible_splat_cull_compact_unit vscc_checker u_vscc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
